FILE: hdl/fla_pkg.sv
package fla_pkg;

  // Field widths
  localparam int ADDR_BITS = 24;
  // Extent bases can run one bit past the address width after splits
  localparam int BASE_W = ADDR_BITS + 1;
  // Width for address sums and compares
  localparam int EXT_W = ADDR_BITS + 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_HEADER_BYTES = 24;

  localparam logic [ADDR_BITS-1:0] AMASK = {ADDR_BITS{1'b1}};

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NULL = 2'd1,
    ST_NOMEM = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic cmd;
    logic [ADDR_BITS-1:0] req_size;
    logic [ADDR_BITS-1:0] free_addr;
  } req_t;

  typedef struct packed {
    status_e status;
    logic [ADDR_BITS-1:0] grant_addr;
    logic [ADDR_BITS-1:0] largest_free;
    logic [ADDR_BITS-1:0] total_free;
  } result_t;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_SHIFT,
    PH_STATS
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_DRAIN,
    S_DECIDE,
    S_PLAN,
    S_SHIFT,
    S_SHIFT_DRAIN,
    S_WRITE,
    S_STATS_INIT,
    S_STATS,
    S_STATS_DRAIN,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic step;
    phase_e phase;
    logic decide;
    logic wr_one;
    logic stats_init;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic cnt_zero;
    logic sh_en;
    logic wr_en;
  } dp_stat_t;

  function automatic logic [ADDR_BITS-1:0] sat_size(input logic [EXT_W-1:0] v);
    logic [ADDR_BITS-1:0] r;
    r = (v > EXT_W'(AMASK)) ? AMASK : v[ADDR_BITS-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/free_list_allocator.sv
// Free list heap allocator over an address-ordered table of free extents.
// Request channel: drive req_i and raise start; a request is taken on a
// rising edge where start is high and busy is low. busy stays high until
// the result has been shown.
// Result channel: result_o is valid for exactly one cycle while
// result_valid_o is high; the receiver cannot hold it off.
// Configuration: cfg_valid_i with cfg_index_i (0 fit mode, 1 heap limit)
// and cfg_data_i; cfg_ready_o is always high. Write only while idle.
// Every phase walks the table one entry per cycle through the single read
// port of the extent memory; the shift phase moves the entries that open
// or close a table slot. One request is in flight; the next one is taken
// in the cycle after the result at the earliest.
// Reset empties the table, zeroes the heap break, selects first fit and
// sets the heap limit to all ones; the table memory itself is not cleared.
module free_list_allocator #(
  parameter int TABLE_DEPTH = fla_pkg::DEF_TABLE_DEPTH,
  parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  fla_pkg::req_t                  req_i,
  output logic                           result_valid_o,
  output fla_pkg::result_t               result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fla_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fla_pkg::ADDR_BITS-1:0]  cfg_data_i
);
  import fla_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  fla_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  fla_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule

FILE: hdl/fla_ctrl.sv
module fla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                result_valid_o,
  input  fla_pkg::dp_stat_t   stat_i,
  output fla_pkg::ctrl_cmd_t  cmd_o
);
  import fla_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = stat_i.cnt_zero ? S_DECIDE : S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.last) state_d = S_SCAN_DRAIN;
      end
      S_SCAN_DRAIN: state_d = S_DECIDE;
      S_DECIDE: state_d = S_PLAN;
      S_PLAN: begin
        priority if (stat_i.sh_en) state_d = S_SHIFT;
        else if (stat_i.wr_en) state_d = S_WRITE;
        else state_d = S_STATS_INIT;
      end
      S_SHIFT: begin
        if (stat_i.last) state_d = S_SHIFT_DRAIN;
      end
      S_SHIFT_DRAIN: state_d = stat_i.wr_en ? S_WRITE : S_STATS_INIT;
      S_WRITE: state_d = S_STATS_INIT;
      S_STATS_INIT: state_d = stat_i.cnt_zero ? S_DONE : S_STATS;
      S_STATS: begin
        if (stat_i.last) state_d = S_STATS_DRAIN;
      end
      S_STATS_DRAIN: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    cmd_o.phase = PH_SCAN;
    busy = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        cmd_o.accept = start;
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.step = 1'b1;
      end
      S_SCAN_DRAIN: cmd_o.phase = PH_SCAN;
      S_DECIDE: cmd_o.decide = 1'b1;
      S_PLAN: ;
      S_SHIFT: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.step = 1'b1;
        cmd_o.phase = PH_SHIFT;
      end
      S_SHIFT_DRAIN: cmd_o.phase = PH_SHIFT;
      S_WRITE: cmd_o.wr_one = 1'b1;
      S_STATS_INIT: cmd_o.stats_init = 1'b1;
      S_STATS: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.step = 1'b1;
        cmd_o.phase = PH_STATS;
      end
      S_STATS_DRAIN: cmd_o.phase = PH_STATS;
      S_DONE: result_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: hdl/fla_dp.sv
module fla_dp #(
  parameter int TABLE_DEPTH = fla_pkg::DEF_TABLE_DEPTH,
  parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fla_pkg::req_t                       req_i,
  input  logic                                cfg_valid_i,
  input  logic [fla_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fla_pkg::ADDR_BITS-1:0]       cfg_data_i,
  input  fla_pkg::ctrl_cmd_t                  cmd_i,
  output fla_pkg::dp_stat_t                   stat_o,
  output fla_pkg::result_t                    result_o
);
  import fla_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [EXT_W-1:0] HB = EXT_W'(HEADER_BYTES);

  // Extent table
  logic [BASE_W-1:0]    mem_base [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] mem_size [TABLE_DEPTH];

  // Control state
  logic [CW-1:0]        count_q;
  logic [ADDR_BITS-1:0] brk_q;
  logic                 fit_q;
  logic [ADDR_BITS-1:0] limit_q;
  logic                 rvld_q;

  // Request and walk pointers
  req_t                 req_q;
  logic [AW-1:0]        ptr_q, end_q, ridx_q;
  logic [BASE_W-1:0]    rbase_q;
  logic [ADDR_BITS-1:0] rsize_q;

  // Scan results
  logic                 done_q, pv_q, exact_q;
  logic [AW-1:0]        pick_q;
  logic [BASE_W-1:0]    pick_b_q;
  logic [ADDR_BITS-1:0] pick_s_q;
  logic                 found_q, prv_q;
  logic [AW-1:0]        p_q;
  logic [BASE_W-1:0]    nb_q, lb_q;
  logic [ADDR_BITS-1:0] ns_q, ls_q;

  // Planned table updates
  logic                 sh_en_q, sh_up_q, wr_en_q;
  logic [AW-1:0]        wa_q;
  logic [BASE_W-1:0]    wb_q;
  logic [ADDR_BITS-1:0] ws_q;

  // Result
  status_e              status_q;
  logic [ADDR_BITS-1:0] grant_q, largest_q, total_q;

  // Decision values
  status_e              status_d;
  logic [ADDR_BITS-1:0] grant_d, brk_d, ws_d;
  logic [CW-1:0]        count_d;
  logic                 sh_en_d, sh_up_d, wr_en_d;
  logic [AW-1:0]        sh_ptr_d, sh_end_d, wa_d;
  logic [BASE_W-1:0]    wb_d;

  logic [EXT_W-1:0]     need, hdr, sz_x;
  logic [CW-1:0]        p_c, pick_c;
  logic                 jn, jp;

  assign need = EXT_W'(req_q.req_size) + HB;
  assign sz_x = EXT_W'(req_q.req_size);
  assign hdr = EXT_W'(req_q.free_addr) - HB;
  assign p_c = found_q ? CW'(p_q) : count_q;
  assign pick_c = CW'(pick_q);
  assign jn = found_q && (EXT_W'(nb_q) == hdr + HB + sz_x);
  assign jp = prv_q && (EXT_W'(lb_q) + HB + EXT_W'(ls_q) == hdr);

  assign stat_o.last = (ptr_q == end_q);
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.sh_en = sh_en_q;
  assign stat_o.wr_en = wr_en_q;

  assign result_o.status = status_q;
  assign result_o.grant_addr = grant_q;
  assign result_o.largest_free = largest_q;
  assign result_o.total_free = total_q;

  // Work out the outcome from the scan
  always_comb begin
    status_d = ST_OK;
    grant_d = '0;
    brk_d = brk_q;
    count_d = count_q;
    sh_en_d = 1'b0;
    sh_up_d = 1'b0;
    sh_ptr_d = ptr_q;
    sh_end_d = end_q;
    wr_en_d = 1'b0;
    wa_d = pick_q;
    wb_d = pick_b_q;
    ws_d = pick_s_q;
    if (req_q.cmd == CMD_ALLOC) begin
      priority if (req_q.req_size == '0) begin
        status_d = ST_NULL;
      end else if (pv_q) begin
        grant_d = ADDR_BITS'(EXT_W'(pick_b_q) + HB);
        if (exact_q) begin
          // take the extent whole: close the gap above it
          count_d = count_q - 1'b1;
          sh_en_d = (pick_c + 1'b1) < count_q;
          sh_ptr_d = AW'(pick_c + 1'b1);
          sh_end_d = AW'(count_q - 1'b1);
        end else begin
          // split: remainder keeps the slot
          wr_en_d = 1'b1;
          wb_d = BASE_W'(EXT_W'(pick_b_q) + need);
          ws_d = ADDR_BITS'(EXT_W'(pick_s_q) - need);
        end
      end else if (EXT_W'(brk_q) + need > EXT_W'(limit_q)) begin
        status_d = ST_NOMEM;
      end else begin
        grant_d = ADDR_BITS'(EXT_W'(brk_q) + HB);
        brk_d = ADDR_BITS'(EXT_W'(brk_q) + need);
      end
    end else begin
      priority if (EXT_W'(req_q.free_addr) < HB) begin
        status_d = ST_NULL;
      end else if (jp && jn) begin
        wr_en_d = 1'b1;
        wa_d = AW'(p_c - 1'b1);
        wb_d = lb_q;
        ws_d = sat_size(EXT_W'(ls_q) + HB + sz_x + HB + EXT_W'(ns_q));
        count_d = count_q - 1'b1;
        sh_en_d = (p_c + 1'b1) < count_q;
        sh_ptr_d = AW'(p_c + 1'b1);
        sh_end_d = AW'(count_q - 1'b1);
      end else if (jp) begin
        wr_en_d = 1'b1;
        wa_d = AW'(p_c - 1'b1);
        wb_d = lb_q;
        ws_d = sat_size(EXT_W'(ls_q) + HB + sz_x);
      end else if (jn) begin
        wr_en_d = 1'b1;
        wa_d = AW'(p_c);
        wb_d = BASE_W'(hdr);
        ws_d = sat_size(sz_x + HB + EXT_W'(ns_q));
      end else if (count_q == DEPTH_C) begin
        status_d = ST_FULL;
      end else begin
        // insert: open a slot at p, then write it
        count_d = count_q + 1'b1;
        sh_en_d = p_c < count_q;
        sh_up_d = 1'b1;
        sh_ptr_d = AW'(count_q - 1'b1);
        sh_end_d = AW'(p_c);
        wr_en_d = 1'b1;
        wa_d = AW'(p_c);
        wb_d = BASE_W'(hdr);
        ws_d = req_q.req_size;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      brk_q <= '0;
      fit_q <= 1'b0;
      limit_q <= AMASK;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= cmd_i.rd_en;
      if (cmd_i.decide) begin
        count_q <= count_d;
        brk_q <= brk_d;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_FIT_MODE: fit_q <= cfg_data_i[0];
          CFG_HEAP_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Table read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rbase_q <= mem_base[ptr_q];
      rsize_q <= mem_size[ptr_q];
      ridx_q <= ptr_q;
    end
  end

  // Table write port: shift beats first, single entry writes otherwise
  always_ff @(posedge clk_i) begin
    if (rvld_q && cmd_i.phase == PH_SHIFT) begin
      mem_base[sh_up_q ? ridx_q + 1'b1 : ridx_q - 1'b1] <= rbase_q;
      mem_size[sh_up_q ? ridx_q + 1'b1 : ridx_q - 1'b1] <= rsize_q;
    end else if (cmd_i.wr_one) begin
      mem_base[wa_q] <= wb_q;
      mem_size[wa_q] <= ws_q;
    end
  end

  // Walk pointer
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.accept) begin
      ptr_q <= '0;
      end_q <= AW'(count_q - 1'b1);
    end else if (cmd_i.decide) begin
      ptr_q <= sh_ptr_d;
      end_q <= sh_end_d;
    end else if (cmd_i.stats_init) begin
      ptr_q <= '0;
      end_q <= AW'(count_q - 1'b1);
    end else if (cmd_i.step) begin
      ptr_q <= (cmd_i.phase == PH_SHIFT && sh_up_q) ? ptr_q - 1'b1 : ptr_q + 1'b1;
    end
  end

  // Capture the request and evaluate scan beats
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
      done_q <= 1'b0;
      pv_q <= 1'b0;
      exact_q <= 1'b0;
      found_q <= 1'b0;
      prv_q <= 1'b0;
    end else if (rvld_q && cmd_i.phase == PH_SCAN) begin
      // allocate: first fit or exact match, else smallest splittable
      if (!done_q) begin
        if (rsize_q == req_q.req_size) begin
          pick_q <= ridx_q;
          pick_b_q <= rbase_q;
          pick_s_q <= rsize_q;
          pv_q <= 1'b1;
          exact_q <= 1'b1;
          done_q <= 1'b1;
        end else if (EXT_W'(rsize_q) >= need) begin
          if (!fit_q) begin
            pick_q <= ridx_q;
            pick_b_q <= rbase_q;
            pick_s_q <= rsize_q;
            pv_q <= 1'b1;
            done_q <= 1'b1;
          end else if (!pv_q || rsize_q < pick_s_q) begin
            pick_q <= ridx_q;
            pick_b_q <= rbase_q;
            pick_s_q <= rsize_q;
            pv_q <= 1'b1;
          end
        end
      end
      // free: find first base above the header, hold its predecessor
      if (!found_q) begin
        if (EXT_W'(rbase_q) > hdr) begin
          found_q <= 1'b1;
          p_q <= ridx_q;
          nb_q <= rbase_q;
          ns_q <= rsize_q;
        end else begin
          prv_q <= 1'b1;
          lb_q <= rbase_q;
          ls_q <= rsize_q;
        end
      end
    end
  end

  // Latch the plan and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      status_q <= status_d;
      grant_q <= grant_d;
      sh_en_q <= sh_en_d;
      sh_up_q <= sh_up_d;
      wr_en_q <= wr_en_d;
      wa_q <= wa_d;
      wb_q <= wb_d;
      ws_q <= ws_d;
    end
    if (cmd_i.stats_init) begin
      largest_q <= '0;
      total_q <= '0;
    end else if (rvld_q && cmd_i.phase == PH_STATS) begin
      if (rsize_q > largest_q) largest_q <= rsize_q;
      total_q <= sat_size(EXT_W'(total_q) + EXT_W'(rsize_q));
    end
  end

endmodule

FILE: verif/tb_free_list_allocator.sv
`timescale 1ns / 100ps

module tb_free_list_allocator;
  import fla_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int HDR = DEF_HEADER_BYTES;
  localparam logic [63:0] SAT = 64'(AMASK);
  localparam int SETTLE_CYCLES = 3 * DEPTH + 30;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    req_t    req;
    bit      known;
    result_t res;
  } row_t;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] size;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  result_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_BITS-1:0] cfg_data_i = '0;

  // Shadow heap state
  logic [63:0] sh_base[DEPTH];
  logic [63:0] sh_size[DEPTH];
  int          sh_count = 0;
  logic [63:0] sh_break = '0;
  bit          sh_fit = 1'b0;
  logic [63:0] sh_limit = SAT;

  result_t pending_results[$];
  block_t  live_blocks[$];
  row_t    directed_rows[$];
  int      errors = 0;
  int      gap_pct = 0;
  int      idle_cycles = 0;

  free_list_allocator i_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void drop_slot(input int i);
    for (int j = i; j < sh_count - 1; j++) begin
      sh_base[j] = sh_base[j+1];
      sh_size[j] = sh_size[j+1];
    end
    sh_count--;
  endfunction

  // Advance the shadow heap by one request and return its result
  function automatic result_t heap_step(input req_t r);
    result_t     o;
    logic [63:0] req, need, hdr, grant, largest, total;
    int          pick, p;
    bit          exact, jp, jn;
    logic [1:0]  st;
    req = 64'(r.req_size);
    grant = '0;
    st = ST_OK;
    if (r.cmd == CMD_ALLOC) begin
      need = req + HDR;
      pick = -1;
      exact = 0;
      if (req == 0) begin
        st = ST_NULL;
      end else begin
        for (int i = 0; i < sh_count; i++) begin
          if (sh_size[i] == req) begin
            pick = i;
            exact = 1;
            break;
          end
          if (sh_size[i] >= need) begin
            if (!sh_fit) begin
              pick = i;
              break;
            end
            if (pick < 0 || sh_size[i] < sh_size[pick]) pick = i;
          end
        end
        if (pick >= 0) begin
          grant = sh_base[pick] + HDR;
          if (exact) begin
            drop_slot(pick);
          end else begin
            sh_base[pick] += need;
            sh_size[pick] -= need;
          end
        end else if (sh_break + need > sh_limit) begin
          st = ST_NOMEM;
        end else begin
          grant = sh_break + HDR;
          sh_break += need;
        end
      end
    end else if (r.free_addr < HDR) begin
      st = ST_NULL;
    end else begin
      hdr = 64'(r.free_addr) - HDR;
      p = 0;
      while (p < sh_count && sh_base[p] <= hdr) p++;
      jn = p < sh_count && sh_base[p] == hdr + HDR + req;
      jp = p > 0 && sh_base[p-1] + HDR + sh_size[p-1] == hdr;
      if (jp && jn) begin
        total = sh_size[p-1] + HDR + req + HDR + sh_size[p];
        sh_size[p-1] = total > SAT ? SAT : total;
        drop_slot(p);
      end else if (jp) begin
        total = sh_size[p-1] + HDR + req;
        sh_size[p-1] = total > SAT ? SAT : total;
      end else if (jn) begin
        sh_base[p] = hdr;
        total = req + HDR + sh_size[p];
        sh_size[p] = total > SAT ? SAT : total;
      end else if (sh_count >= DEPTH) begin
        st = ST_FULL;
      end else begin
        for (int j = sh_count; j > p; j--) begin
          sh_base[j] = sh_base[j-1];
          sh_size[j] = sh_size[j-1];
        end
        sh_base[p] = hdr;
        sh_size[p] = req;
        sh_count++;
      end
    end
    largest = '0;
    total = '0;
    for (int i = 0; i < sh_count; i++) begin
      if (sh_size[i] > largest) largest = sh_size[i];
      total = total + sh_size[i];
      if (total > SAT) total = SAT;
    end
    o.status = status_e'(st);
    o.grant_addr = grant[ADDR_BITS-1:0];
    o.largest_free = largest[ADDR_BITS-1:0];
    o.total_free = total[ADDR_BITS-1:0];
    return o;
  endfunction

  // Send one request beat; called and returns at a falling edge
  task automatic send_request(input req_t r, input bit known, input result_t typed,
                              output result_t got);
    int gap;
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
    end
    req_i = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    got = heap_step(r);
    pending_results.push_back(known ? typed : got);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_BITS-1:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FIT_MODE) sh_fit = val[0];
    else sh_limit = 64'(val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void add_row(input logic cmd, input logic [23:0] sz, input logic [23:0] ad,
                                  input bit known, input logic [1:0] st, input logic [23:0] g,
                                  input logic [23:0] lg, input logic [23:0] tot);
    row_t w;
    w.req.cmd = cmd;
    w.req.req_size = sz;
    w.req.free_addr = ad;
    w.known = known;
    w.res.status = status_e'(st);
    w.res.grant_addr = g;
    w.res.largest_free = lg;
    w.res.total_free = tot;
    directed_rows.push_back(w);
  endfunction

  // Track live blocks so most frees return what was granted
  task automatic send_tracked(input req_t r);
    result_t got;
    send_request(r, 1'b0, got, got);
    if (r.cmd == CMD_ALLOC && got.status == ST_OK)
      live_blocks.push_back('{got.grant_addr, r.req_size});
  endtask

  task automatic random_phase(input int count);
    req_t r;
    int   sel, k;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      r.cmd = CMD_ALLOC;
      r.free_addr = 24'($urandom());
      r.req_size = (($urandom_range(19) == 0) ? 24'($urandom()) : 24'($urandom_range(1, 64)));
      if (sel >= 45 && sel < 85 && live_blocks.size() != 0) begin
        k = $urandom_range(live_blocks.size() - 1);
        r.cmd = CMD_FREE;
        r.free_addr = live_blocks[k].addr;
        r.req_size = live_blocks[k].size;
        live_blocks.delete(k);
      end else if (sel >= 85 && sel < 92) begin
        if (sh_count != 0) r.req_size = sh_size[$urandom_range(sh_count - 1)][23:0];
        else r.req_size = '0;
      end else if (sel >= 92) begin
        r.cmd = CMD_FREE;
        r.req_size = 24'($urandom());
      end
      send_tracked(r);
    end
  endtask

  // Fragment the heap so frees run into a full table
  task automatic fragment_burst();
    req_t   r;
    block_t held[$];
    int     base_n;
    base_n = live_blocks.size();
    r.cmd = CMD_ALLOC;
    r.free_addr = '0;
    r.req_size = 24'd8;
    repeat (140) send_tracked(r);
    while (live_blocks.size() > base_n) held.push_back(live_blocks.pop_back());
    for (int i = 0; i < held.size(); i++) begin
      if (i % 2 == 0) begin
        r.cmd = CMD_FREE;
        r.free_addr = held[i].addr;
        r.req_size = held[i].size;
        send_tracked(r);
      end else begin
        live_blocks.push_back(held[i]);
      end
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", result_o.status, want.status));
        if (result_o.grant_addr !== want.grant_addr)
          report_mismatch($sformatf("grant %h want %h", result_o.grant_addr, want.grant_addr));
        if (result_o.largest_free !== want.largest_free)
          report_mismatch($sformatf("largest %h want %h", result_o.largest_free,
                                    want.largest_free));
        if (result_o.total_free !== want.total_free)
          report_mismatch($sformatf("total %h want %h", result_o.total_free, want.total_free));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    result_t got;
    add_row(CMD_ALLOC, 24'd0, 24'd0, 1, ST_NULL, 24'd0, 24'd0, 24'd0);
    add_row(CMD_ALLOC, 24'd100, 24'hFFFFFF, 1, ST_OK, 24'd24, 24'd0, 24'd0);
    add_row(CMD_FREE, 24'd5, 24'd0, 1, ST_NULL, 24'd0, 24'd0, 24'd0);
    add_row(CMD_FREE, 24'd5, 24'd23, 1, ST_NULL, 24'd0, 24'd0, 24'd0);
    add_row(CMD_FREE, 24'd100, 24'd24, 1, ST_OK, 24'd0, 24'd100, 24'd100);
    add_row(CMD_ALLOC, 24'd100, 24'd0, 1, ST_OK, 24'd24, 24'd0, 24'd0);
    add_row(CMD_ALLOC, 24'hFFFFFF, 24'd0, 1, ST_NOMEM, 24'd0, 24'd0, 24'd0);
    add_row(CMD_FREE, 24'd100, 24'd24, 1, ST_OK, 24'd0, 24'd100, 24'd100);
    add_row(CMD_ALLOC, 24'd40, 24'd0, 0, 0, 0, 0, 0);
    add_row(CMD_ALLOC, 24'd10, 24'd0, 0, 0, 0, 0, 0);
    add_row(CMD_ALLOC, 24'd36, 24'd0, 0, 0, 0, 0, 0);
    add_row(CMD_FREE, 24'd40, 24'd24, 0, 0, 0, 0, 0);
    add_row(CMD_FREE, 24'd36, 24'd122, 0, 0, 0, 0, 0);
    add_row(CMD_FREE, 24'd10, 24'd88, 0, 0, 0, 0, 0);
    add_row(CMD_FREE, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0, 0);
    add_row(CMD_FREE, 24'd0, 24'hFFFF00, 0, 0, 0, 0, 0);
    add_row(CMD_FREE, 24'h7FFFFF, 24'h800000, 0, 0, 0, 0, 0);
    add_row(CMD_ALLOC, 24'hFFFFFF, 24'd0, 0, 0, 0, 0, 0);
    add_row(CMD_ALLOC, 24'h100000, 24'd0, 0, 0, 0, 0, 0);
    add_row(CMD_ALLOC, 24'd1, 24'd0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed walk with reset configuration
    gap_pct = 0;
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res, got);

    // Random phases, each under its own configuration
    wait_drained();
    write_reg(CFG_FIT_MODE, 24'd1);
    write_reg(CFG_HEAP_LIMIT, 24'hFFFFFF);
    gap_pct = 35;
    random_phase(400);
    fragment_burst();

    wait_drained();
    write_reg(CFG_FIT_MODE, 24'd0);
    write_reg(CFG_HEAP_LIMIT, 24'($urandom_range(24'h4000, 24'h40000)));
    gap_pct = 70;
    random_phase(400);

    wait_drained();
    write_reg(CFG_FIT_MODE, 24'd1);
    write_reg(CFG_HEAP_LIMIT, 24'd0);
    gap_pct = 0;
    random_phase(150);

    wait_drained();
    write_reg(CFG_FIT_MODE, 24'd0);
    write_reg(CFG_HEAP_LIMIT, 24'hFFFFFF);
    random_phase(460);
    fragment_burst();

    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
